FILE: sv/pointer_motion_threshold_gate_core_defines.svh
// Assertion helpers shared by the gate's modules.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef POINTER_MOTION_THRESHOLD_GATE_CORE_DEFINES_SVH
`define POINTER_MOTION_THRESHOLD_GATE_CORE_DEFINES_SVH

// Same-cycle implication.
`define PMTG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pmtg_pkg.sv
package pmtg_pkg;

  localparam int SUM_BITS  = 24;
  localparam int TIME_BITS = 32;

  localparam int CMD_W    = 2;
  localparam int DELTA_W  = 16;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;
  localparam int THR_SQ_W = 2 * CFG_W;
  localparam int SQ_W     = 2 * SUM_BITS + 1;

  localparam int Q_AW    = 2;
  localparam int Q_DEPTH = 1 << Q_AW;
  localparam int Q_CW    = Q_AW + 1;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_X   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_Y   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_KEY = 2'd2;

  // Register indexes.
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_KEY_IDLE  = 2'd2;

  // Classification made by the front end.
  localparam logic [1:0] KIND_NOP   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_MOVE  = 2'd2;

  // Operation handed from the accumulator to the arming pipeline.
  localparam logic [1:0] OP_NOP     = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_MOVE    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                kind;
    logic                      axis_y;
    logic signed [DELTA_W-1:0] delta;
    logic [TIME_BITS-1:0]      now;
    logic                      layer;
  } evt_word_t;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [SUM_BITS-1:0] sum_x;
    logic signed [SUM_BITS-1:0] sum_y;
    logic                       layer;
  } acc_word_t;

endpackage

FILE: sv/pmtg_if.sv
interface pmtg_in_if;
  import pmtg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [DELTA_W-1:0] delta;
  logic [TIME_W-1:0]         time_ms;
  logic                      layer_active;

  modport source (output valid, output cmd, output delta, output time_ms,
                  output layer_active, input ready);
  modport sink (input valid, input cmd, input delta, input time_ms,
                input layer_active, output ready);
endinterface

interface pmtg_out_if;
  logic valid;
  logic ready;
  logic pass_on;
  logic armed_now;

  modport source (output valid, output pass_on, output armed_now, input ready);
  modport sink (input valid, input pass_on, input armed_now, output ready);
endinterface

FILE: sv/pointer_motion_threshold_gate_core.sv
// Pointer motion threshold gate. Takes one event word per cycle on evt while the
// queue has room (motion X, motion Y or key press, with a millisecond time stamp)
// and returns exactly one result word per event on res, in order: pass_on says
// whether a motion word goes on, armed_now gives the armed flag after that event.
// Throughput is one word per clock, unless res.ready holds back the output, set
// by the single accumulate-and-saturate stage that owns the X/Y sums and the last
// motion time. The classifier writes a four-entry queue at the accepting edge,
// then the accumulator adds, a register takes magnitudes, another squares, and a
// compare against the squared threshold loads the output register. Registers sit
// on the APB port at byte addresses 0 (distance threshold), 4 (activation window)
// and 8 (key idle time) and should be written only while no event is in flight.
module pointer_motion_threshold_gate_core (
  input  logic                          clk,
  input  logic                          rst,
  pmtg_in_if.sink                       evt,
  pmtg_out_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmtg_pkg::APB_AW-1:0]   paddr,
  input  logic [pmtg_pkg::APB_DW-1:0]   pwdata,
  output logic [pmtg_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import pmtg_pkg::*;

  logic [CFG_W-1:0] distance_threshold;
  logic [CFG_W-1:0] activation_window;
  logic [CFG_W-1:0] key_idle_time;
  logic [1:0]       reg_index;
  logic             cfg_write;

  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  evt_word_t        push_word;
  evt_word_t        q_word;
  logic             acc_valid;
  logic             acc_ready;
  acc_word_t        acc_word;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (reg_index)
      REG_THRESHOLD: prdata = APB_DW'(distance_threshold);
      REG_WINDOW:    prdata = APB_DW'(activation_window);
      REG_KEY_IDLE:  prdata = APB_DW'(key_idle_time);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_threshold <= CFG_W'(10);
      activation_window  <= CFG_W'(500);
      key_idle_time      <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_THRESHOLD: distance_threshold <= pwdata[CFG_W-1:0];
        REG_WINDOW:    activation_window  <= pwdata[CFG_W-1:0];
        REG_KEY_IDLE:  key_idle_time      <= pwdata[CFG_W-1:0];
        default:       ;
      endcase
    end
  end

  pmtg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .evt           (evt),
    .key_idle_time (key_idle_time),
    .q_full        (q_full),
    .push          (push),
    .push_word     (push_word)
  );

  pmtg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (pop),
    .pop_word  (q_word),
    .empty     (q_empty)
  );

  pmtg_back u_back (
    .clk               (clk),
    .rst               (rst),
    .activation_window (activation_window),
    .q_word            (q_word),
    .q_empty           (q_empty),
    .pop               (pop),
    .acc_valid         (acc_valid),
    .acc_word          (acc_word),
    .acc_ready         (acc_ready)
  );

  pmtg_arm u_arm (
    .clk                (clk),
    .rst                (rst),
    .distance_threshold (distance_threshold),
    .acc_valid          (acc_valid),
    .acc_word           (acc_word),
    .acc_ready          (acc_ready),
    .res                (res)
  );

endmodule

FILE: sv/pmtg_queue.sv
`include "pointer_motion_threshold_gate_core_defines.svh"

module pmtg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pmtg_pkg::evt_word_t push_word,
  output logic                full,
  input  logic                pop,
  output pmtg_pkg::evt_word_t pop_word,
  output logic                empty
);
  import pmtg_pkg::*;

  evt_word_t             entries [Q_DEPTH];
  logic [Q_AW-1:0]       wr_ptr;
  logic [Q_AW-1:0]       rd_ptr;
  logic [Q_CW-1:0]       count;

  assign full     = (count == Q_CW'(Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_word = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `PMTG_ASSERT_NOW(a_count_bound, 1'b1, count <= Q_CW'(Q_DEPTH), "queue count exceeds depth")
  `PMTG_ASSERT_NEXT(a_count_step, push && !pop, count == $past(count) + 1'b1,
                    "queue count did not follow a lone push")
  `PMTG_ASSERT_NOW(a_no_overrun, full, !push, "push into a full queue")

endmodule

FILE: sv/pmtg_front.sv
module pmtg_front (
  input  logic                clk,
  input  logic                rst,
  pmtg_in_if.sink             evt,
  input  logic [pmtg_pkg::CFG_W-1:0] key_idle_time,
  input  logic                q_full,
  output logic                push,
  output pmtg_pkg::evt_word_t push_word
);
  import pmtg_pkg::*;

  logic [TIME_BITS-1:0] last_key_time;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS:0]   key_gap;
  logic                 blocked;

  assign now = TIME_BITS'(evt.time_ms);

  // The borrow bit flags a time that went backwards past the last key press.
  assign key_gap = {1'b0, now} - {1'b0, last_key_time};
  assign blocked = (key_idle_time != '0) &&
                   (key_gap[TIME_BITS] ||
                    (key_gap[TIME_BITS-1:0] < TIME_BITS'(key_idle_time)));

  // No word is taken while reset is held.
  assign evt.ready = !q_full && !rst;
  assign push      = evt.valid && evt.ready;

  always_comb begin
    push_word.axis_y = (evt.cmd == CMD_Y);
    push_word.delta  = evt.delta;
    push_word.now    = now;
    push_word.layer  = evt.layer_active;
    unique case (evt.cmd) inside
      CMD_KEY: begin
        push_word.kind = KIND_CLEAR;
      end
      CMD_X, CMD_Y: begin
        if (evt.delta == '0) push_word.kind = KIND_NOP;
        else if (blocked) push_word.kind = KIND_CLEAR;
        else push_word.kind = KIND_MOVE;
      end
      default: begin
        push_word.kind = KIND_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_key_time <= '0;
    end else if (push && evt.cmd == CMD_KEY) begin
      last_key_time <= now;
    end
  end

endmodule

FILE: sv/pmtg_back.sv
module pmtg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [pmtg_pkg::CFG_W-1:0] activation_window,
  input  pmtg_pkg::evt_word_t q_word,
  input  logic                q_empty,
  output logic                pop,
  output logic                acc_valid,
  output pmtg_pkg::acc_word_t acc_word,
  input  logic                acc_ready
);
  import pmtg_pkg::*;

  logic signed [SUM_BITS-1:0] sum_x;
  logic signed [SUM_BITS-1:0] sum_y;
  logic [TIME_BITS-1:0]       last_motion_time;
  logic [1:0]                 op;
  logic                       layer;

  logic                       slot_free;
  logic [TIME_BITS:0]         motion_gap;
  logic                       restart;
  logic signed [SUM_BITS-1:0] base;
  logic signed [SUM_BITS:0]   wide;
  logic signed [SUM_BITS-1:0] sat;

  assign slot_free = !acc_valid || acc_ready;
  assign pop       = slot_free && !q_empty;

  // A gap counts only when time moved forward past the last motion.
  assign motion_gap = {1'b0, q_word.now} - {1'b0, last_motion_time};
  assign restart    = (last_motion_time != '0) && !motion_gap[TIME_BITS] &&
                      (motion_gap[TIME_BITS-1:0] > TIME_BITS'(activation_window));

  always_comb begin
    if (restart) base = '0;
    else if (q_word.axis_y) base = sum_y;
    else base = sum_x;
    wide = (SUM_BITS+1)'(base) + (SUM_BITS+1)'(q_word.delta);
    if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
      sat = wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      sat = wide[SUM_BITS-1:0];
    end
  end

  assign acc_word.op    = op;
  assign acc_word.sum_x = sum_x;
  assign acc_word.sum_y = sum_y;
  assign acc_word.layer = layer;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid        <= 1'b0;
      sum_x            <= '0;
      sum_y            <= '0;
      last_motion_time <= '0;
      op               <= OP_NOP;
      layer            <= 1'b0;
    end else begin
      if (slot_free) acc_valid <= pop;
      if (pop) begin
        layer <= q_word.layer;
        case (q_word.kind)
          KIND_CLEAR: begin
            sum_x            <= '0;
            sum_y            <= '0;
            last_motion_time <= '0;
            op               <= OP_CLEAR;
          end
          KIND_MOVE: begin
            last_motion_time <= q_word.now;
            if (q_word.axis_y) begin
              sum_y <= sat;
              if (restart) sum_x <= '0;
            end else begin
              sum_x <= sat;
              if (restart) sum_y <= '0;
            end
            op <= restart ? OP_RESTART : OP_MOVE;
          end
          default: begin
            op <= OP_NOP;
          end
        endcase
      end
    end
  end

endmodule

FILE: sv/pmtg_arm.sv
`include "pointer_motion_threshold_gate_core_defines.svh"

module pmtg_arm (
  input  logic                clk,
  input  logic                rst,
  input  logic [pmtg_pkg::CFG_W-1:0] distance_threshold,
  input  logic                acc_valid,
  input  pmtg_pkg::acc_word_t acc_word,
  output logic                acc_ready,
  pmtg_out_if.source          res
);
  import pmtg_pkg::*;

  logic [THR_SQ_W-1:0]   thr_sq;

  logic                  s1_v;
  logic [1:0]            s1_op;
  logic                  s1_layer;
  logic [SUM_BITS-1:0]   mag_x;
  logic [SUM_BITS-1:0]   mag_y;

  logic                  s2_v;
  logic [1:0]            s2_op;
  logic                  s2_layer;
  logic [2*SUM_BITS-1:0] sq_x;
  logic [2*SUM_BITS-1:0] sq_y;

  logic                  armed;
  logic                  armed_next;
  logic                  pass_next;
  logic                  reach;
  logic                  adv_out;
  logic                  s2_rdy;
  logic                  s1_rdy;

  assign adv_out   = !res.valid || res.ready;
  assign s2_rdy    = !s2_v || adv_out;
  assign s1_rdy    = !s1_v || s2_rdy;
  assign acc_ready = s1_rdy;

  assign reach = (SQ_W'(sq_x) + SQ_W'(sq_y)) >= SQ_W'(thr_sq);

  always_comb begin
    armed_next = armed;
    pass_next  = 1'b0;
    case (s2_op)
      OP_CLEAR: begin
        armed_next = 1'b0;
      end
      OP_MOVE: begin
        armed_next = armed || reach;
        pass_next  = armed_next || s2_layer;
      end
      OP_RESTART: begin
        armed_next = reach;
        pass_next  = armed_next || s2_layer;
      end
      default: begin
        armed_next = armed;
      end
    endcase
  end

  // Threshold squared each cycle; user writes only while idle, unchecked.
  always_ff @(posedge clk) begin
    thr_sq <= distance_threshold * distance_threshold;
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_op    <= acc_word.op;
      s1_layer <= acc_word.layer;
      mag_x    <= acc_word.sum_x[SUM_BITS-1] ? -acc_word.sum_x : acc_word.sum_x;
      mag_y    <= acc_word.sum_y[SUM_BITS-1] ? -acc_word.sum_y : acc_word.sum_y;
    end
    if (s2_rdy) begin
      s2_op    <= s1_op;
      s2_layer <= s1_layer;
      sq_x     <= mag_x * mag_x;
      sq_y     <= mag_y * mag_y;
    end
    if (adv_out && s2_v) begin
      res.pass_on   <= pass_next;
      res.armed_now <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      res.valid <= 1'b0;
      armed     <= 1'b0;
    end else begin
      if (s1_rdy) s1_v <= acc_valid;
      if (s2_rdy) s2_v <= s1_v;
      if (adv_out) res.valid <= s2_v;
      if (adv_out && s2_v) armed <= armed_next;
    end
  end

  `PMTG_ASSERT_NEXT(a_clear_disarms, s2_v && adv_out && s2_op == OP_CLEAR,
                    !res.armed_now && !res.pass_on, "clear did not disarm")
  `PMTG_ASSERT_NOW(a_arm_from_move,
                   $rose(armed),
                   $past(s2_v && adv_out && (s2_op == OP_MOVE || s2_op == OP_RESTART)),
                   "armed rose without a motion word")
  `PMTG_ASSERT_NOW(a_armed_matches, res.valid, res.armed_now == armed,
                   "output armed flag differs from armed state")

endmodule
